// ===== rtl/sdbc_pkg.sv =====
// Shared constants for the battery-compensated solenoid duty unit.
// No dependencies; imported by the top level.
package sdbc_pkg;

  // Default full-scale duty, 0.1 percent units.
  localparam int DUTY_FULL_SCALE_DEF = 1000;

  // Field widths of the stream items and of the internal datapath.
  localparam int REQ_W  = 16;
  localparam int BATT_W = 16;
  localparam int POS_W  = 8;
  localparam int OUT_W  = 10;
  localparam int FIL_W  = 8;
  localparam int PREV_W = 12;
  localparam int SUM_W  = 17;
  localparam int MUL_W  = 10;

  // Battery filter constants.
  localparam int BATT_PREV_MAX = 3200;
  localparam int BATT_FIL_MAX  = 200;
  localparam int BATT_BIAS     = 10;
  localparam int BATT_DIV      = 20;
  // Sums from this value upwards filter to the ceiling of the range.
  localparam int BATT_SUM_SAT  = BATT_FIL_MAX * BATT_DIV;
  // Reciprocal of the filter divisor, 16 fractional bits; exact below the ceiling.
  localparam int BATT_RECIP    = 3277;

  // Actuator test scaling.
  localparam int TEST_MUL = 125;
  localparam int TEST_ADD = 16;
  localparam int TEST_SHR = 5;

  // Configuration register indexes.
  localparam logic [1:0] REG_CORR_EN = 2'd0;
  localparam logic [1:0] REG_NOMINAL = 2'd1;
  localparam logic [1:0] REG_DRV_MIN = 2'd2;
  localparam logic [1:0] REG_DRV_MAX = 2'd3;

  // Register reset values.
  localparam logic [7:0] NOMINAL_RST = 8'd135;
  localparam logic [9:0] DRV_MAX_RST = 10'd1000;

endpackage

// ===== rtl/solenoid_duty_battery_compensation_unit.sv =====
// Battery-compensated solenoid duty unit: stream in, stream out, APB registers.
// Depends on sdbc_pkg for constants and register indexes.
//
// One item in, one result out. Each item takes a filter step, then one or two
// passes through a shared bit-serial multiplier and a shared restoring divider
// that works out one quotient bit per cycle over a dividend of DVW = FW + 10
// bits, FW being the width of DUTY_FULL_SCALE (DVW is 20 at the default).
// The unit takes no new item until the previous one has left the mapping
// step. A new item is taken while the previous result still waits in the
// output register. Registers must be written only while the unit is idle;
// the unit itself does not enforce this.
module solenoid_duty_battery_compensation_unit #(
  parameter int DUTY_FULL_SCALE = sdbc_pkg::DUTY_FULL_SCALE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] duty_request, [31:16] battery_sample, [32] test_active,
  // [40:33] test_position, [47:41] zero
  input  logic [47:0] s_tdata,
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // [9:0] drive_duty, [19:10] applied_duty, [29:20] corrected_duty,
  // [37:30] filtered_battery, [39:38] zero
  output logic [39:0] m_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import sdbc_pkg::*;

  localparam int FW  = $clog2(DUTY_FULL_SCALE + 1);
  localparam int DSW = (FW > FIL_W) ? FW : FIL_W;
  localparam int DVW = FW + MUL_W;
  localparam int MPW = DVW + 2;
  localparam int CW  = $clog2(DVW + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILT = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_CORR = 3'd5;
  localparam logic [2:0] ST_MAP  = 3'd6;

  // Configuration registers.
  logic             corr_en;
  logic [7:0]       nominal;
  logic [9:0]       drv_min;
  logic [9:0]       drv_max;

  // Control state.
  logic [2:0]       state;
  logic [CW-1:0]    cnt;
  logic             pass;
  logic [PREV_W-1:0] prev_batt;
  logic             out_valid;

  // Item data held through the computation.
  logic signed [SUM_W-1:0] sum;
  logic [FW-1:0]    capped;
  logic             test;
  logic [OUT_W-1:0] test_duty;
  logic [FIL_W-1:0] fil;
  logic [FW-1:0]    corr;

  // Serial arithmetic datapath.
  logic [FW-1:0]    mul_a;
  logic [MUL_W-1:0] mul_b;
  logic [DVW-1:0]   work;
  logic [DVW-1:0]   rnd;
  logic [DSW-1:0]   divisor;
  logic [DSW-1:0]   rem;

  // Output register.
  logic [OUT_W-1:0] o_drive;
  logic [OUT_W-1:0] o_applied;
  logic [OUT_W-1:0] o_corr;
  logic [FIL_W-1:0] o_fil;

  // Input fields.
  logic [REQ_W-1:0]         in_req;
  logic signed [BATT_W-1:0] in_batt;
  logic                     in_test;
  logic [POS_W-1:0]         in_pos;

  assign in_req  = s_tdata[15:0];
  assign in_batt = $signed(s_tdata[31:16]);
  assign in_test = s_tdata[32];
  assign in_pos  = s_tdata[40:33];

  logic accept;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Filter sum, clamped sample for the next item, capped request and test duty.
  logic signed [SUM_W-1:0]  sum_in;
  logic [PREV_W-1:0]        prev_next;
  logic [FW-1:0]            capped_in;
  logic [POS_W+7:0]         test_prod;

  always_comb begin
    sum_in = SUM_W'(in_batt) + $signed({{(SUM_W-PREV_W){1'b0}}, prev_batt})
             + SUM_W'(BATT_BIAS);
    if (in_batt < 0) begin
      prev_next = '0;
    end else if (in_batt > BATT_W'(BATT_PREV_MAX)) begin
      prev_next = PREV_W'(BATT_PREV_MAX);
    end else begin
      prev_next = in_batt[PREV_W-1:0];
    end
    if (in_req > REQ_W'(DUTY_FULL_SCALE)) begin
      capped_in = FW'(DUTY_FULL_SCALE);
    end else begin
      capped_in = in_req[FW-1:0];
    end
    test_prod = (POS_W+8)'(in_pos) * (POS_W+8)'(TEST_MUL) + (POS_W+8)'(TEST_ADD);
  end

  // Filtered battery: negative sums give zero, the top of the range saturates,
  // everything in between divides by a reciprocal multiply.
  logic [FIL_W-1:0] fil_calc;
  logic [23:0]      recip_prod;

  always_comb begin
    recip_prod = 24'(sum[11:0]) * 24'(BATT_RECIP);
    if (sum[SUM_W-1]) begin
      fil_calc = '0;
    end else if (sum >= SUM_W'(BATT_SUM_SAT)) begin
      fil_calc = FIL_W'(BATT_FIL_MAX);
    end else begin
      fil_calc = recip_prod[23:16];
    end
  end

  // Corrected duty chosen for the mapping pass: direct from the filter state,
  // or the capped quotient of the correction pass.
  logic [FW-1:0] corr_sel;
  logic          span_up;
  logic [9:0]    span;

  always_comb begin
    if (state == ST_FILT) begin
      corr_sel = corr_en ? '0 : capped;
    end else if (work > DVW'(DUTY_FULL_SCALE)) begin
      corr_sel = FW'(DUTY_FULL_SCALE);
    end else begin
      corr_sel = work[FW-1:0];
    end
    span_up = drv_max > drv_min;
    span    = span_up ? (drv_max - drv_min) : (drv_min - drv_max);
  end

  // One restoring divider step.
  logic [DSW:0] rem_sh;
  logic         q_bit;

  always_comb begin
    rem_sh = {rem, work[DVW-1]};
    q_bit  = rem_sh >= {1'b0, divisor};
  end

  // Mapping into the drive span, clamped between zero and full scale.
  logic signed [MPW-1:0] map_val;
  logic [FW-1:0]         drive_calc;

  always_comb begin
    if (span_up) begin
      map_val = $signed(MPW'(drv_min)) + $signed(MPW'(work));
    end else begin
      map_val = $signed(MPW'(drv_min)) - $signed(MPW'(work));
    end
    if (map_val < 0) begin
      drive_calc = '0;
    end else if (map_val > MPW'(DUTY_FULL_SCALE)) begin
      drive_calc = FW'(DUTY_FULL_SCALE);
    end else begin
      drive_calc = map_val[FW-1:0];
    end
  end

  // Sequencer and serial datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      pass      <= 1'b0;
      prev_batt <= '0;
      out_valid <= 1'b0;
    end else begin
      // The mapping step refills the output register on its own.
      if (out_valid && m_tready && (state != ST_MAP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            sum       <= sum_in;
            prev_batt <= prev_next;
            capped    <= capped_in;
            test      <= in_test;
            test_duty <= test_prod[TEST_SHR+OUT_W-1:TEST_SHR];
            state     <= ST_FILT;
          end
        end
        ST_FILT: begin
          fil  <= fil_calc;
          work <= '0;
          cnt  <= '0;
          if (corr_en && (fil_calc != '0)) begin
            // Correction pass: capped * nominal / filtered, rounded.
            mul_a   <= capped;
            mul_b   <= MUL_W'(nominal);
            rnd     <= DVW'(fil_calc >> 1);
            divisor <= DSW'(fil_calc);
            pass    <= 1'b0;
          end else begin
            corr    <= corr_sel;
            mul_a   <= corr_sel;
            mul_b   <= span;
            rnd     <= DVW'(DUTY_FULL_SCALE / 2);
            divisor <= DSW'(DUTY_FULL_SCALE);
            pass    <= 1'b1;
          end
          state <= ST_MUL;
        end
        ST_MUL: begin
          // Shift-and-add, multiplier bits taken from the top.
          work  <= (work << 1) + (mul_b[MUL_W-1] ? DVW'(mul_a) : '0);
          mul_b <= mul_b << 1;
          cnt   <= cnt + 1'b1;
          if (cnt == CW'(MUL_W - 1)) begin
            state <= ST_RND;
          end
        end
        ST_RND: begin
          work  <= work + rnd;
          rem   <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (q_bit) begin
            rem <= DSW'(rem_sh - {1'b0, divisor});
          end else begin
            rem <= rem_sh[DSW-1:0];
          end
          work <= {work[DVW-2:0], q_bit};
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(DVW - 1)) begin
            state <= pass ? ST_MAP : ST_CORR;
          end
        end
        ST_CORR: begin
          // Mapping pass: corrected * span / full scale, rounded.
          corr    <= corr_sel;
          mul_a   <= corr_sel;
          mul_b   <= span;
          rnd     <= DVW'(DUTY_FULL_SCALE / 2);
          divisor <= DSW'(DUTY_FULL_SCALE);
          pass    <= 1'b1;
          work    <= '0;
          cnt     <= '0;
          state   <= ST_MUL;
        end
        ST_MAP: begin
          // Wait here until the output register is free.
          if (!out_valid || m_tready) begin
            o_drive   <= OUT_W'(drive_calc);
            o_applied <= test ? test_duty : OUT_W'(drive_calc);
            o_corr    <= OUT_W'(corr);
            o_fil     <= fil;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, o_fil, o_corr, o_applied, o_drive};

  // Configuration writes and reads.
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      corr_en <= 1'b0;
      nominal <= NOMINAL_RST;
      drv_min <= '0;
      drv_max <= DRV_MAX_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CORR_EN: corr_en <= pwdata[0];
        REG_NOMINAL: nominal <= pwdata[7:0];
        REG_DRV_MIN: drv_min <= pwdata[9:0];
        REG_DRV_MAX: drv_max <= pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CORR_EN: prdata = 32'(corr_en);
      REG_NOMINAL: prdata = 32'(nominal);
      REG_DRV_MIN: prdata = 32'(drv_min);
      REG_DRV_MAX: prdata = 32'(drv_max);
      default:     prdata = '0;
    endcase
  end

`ifndef SYNTHESIS
  // Only one item is in flight: an accepted item blocks the input next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in progress");

  // A result only appears at the end of the mapping step.
  a_result_from_map: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_MAP))
    else $error("result raised outside the mapping step");

  // The divider remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < divisor))
    else $error("divider remainder out of range");

  // The filtered battery never leaves its range.
  a_fil_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_fil <= FIL_W'(BATT_FIL_MAX)))
    else $error("filtered battery above its ceiling");
`endif

endmodule
